@@ sv/phe_pkg.sv @@
// Shared types and constants for the pixel histogram engine.
// No dependencies; every other file uses it through scoped names.
package phe_pkg;

    // Field widths fixed by the item format
    localparam int PIXEL_W     = 8;
    localparam int INDEX_W     = 8;
    localparam int OUT_COUNT_W = 24;
    localparam int BIN_COUNT_W = 9;
    localparam int PDATA_W     = 32;
    localparam int PADDR_W     = 3;

    localparam logic [BIN_COUNT_W-1:0] BIN_COUNT_RST = 9'd30;

    // Register word index (paddr[2])
    localparam logic REG_BIN_COUNT = 1'b0;

    // Commands
    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_COUNT = 2'd0;
    localparam t_cmd CMD_READ  = 2'd1;
    localparam t_cmd CMD_PEAK  = 2'd2;

    // Bin store access controls
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_store_ctl;

endpackage

@@ sv/phe_cfg_regs.sv @@
// APB register file for the pixel histogram engine: bin_count register.
// Depends on phe_pkg. Drives the clamped bin count used by the datapath.
module phe_cfg_regs #(
    parameter int MAX_BINS = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [phe_pkg::PADDR_W-1:0]   paddr,
    input  logic [phe_pkg::PDATA_W-1:0]   pwdata,
    output logic [phe_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output logic [phe_pkg::BIN_COUNT_W-1:0] o_eff_bins
);

    localparam logic [phe_pkg::BIN_COUNT_W-1:0] MAX_BINS_V =
        phe_pkg::BIN_COUNT_W'(MAX_BINS);

    logic [phe_pkg::BIN_COUNT_W-1:0] r_bin_count;
    logic                            w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite &&
                    (paddr[2] == phe_pkg::REG_BIN_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_count <= phe_pkg::BIN_COUNT_RST;
        end else if (w_wr) begin
            r_bin_count <= pwdata[phe_pkg::BIN_COUNT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == phe_pkg::REG_BIN_COUNT) begin
            prdata = {{(phe_pkg::PDATA_W - phe_pkg::BIN_COUNT_W){1'b0}}, r_bin_count};
        end
    end

    // zero acts as one bin, anything above the store depth as the full store
    always_comb begin
        if (r_bin_count == '0) begin
            o_eff_bins = phe_pkg::BIN_COUNT_W'(1);
        end else if (r_bin_count > MAX_BINS_V) begin
            o_eff_bins = MAX_BINS_V;
        end else begin
            o_eff_bins = r_bin_count;
        end
    end

endmodule

@@ sv/phe_bin_store.sv @@
// Bin counter memory: synchronous read, one write port,
// per-entry valid bits for reset clearing and write-to-read forwarding. Uses phe_pkg.
module phe_bin_store #(
    parameter int MAX_BINS    = 256,
    parameter int COUNT_WIDTH = 24,
    parameter int AW          = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  phe_pkg::t_store_ctl     i_ctl,
    input  logic [AW-1:0]           i_rd_addr,
    input  logic [AW-1:0]           i_wr_addr,
    input  logic [COUNT_WIDTH-1:0]  i_wr_data,
    output logic [COUNT_WIDTH-1:0]  o_rd_data
);

    logic [COUNT_WIDTH-1:0] r_mem [MAX_BINS];
    logic [MAX_BINS-1:0]    r_valid;
    logic [COUNT_WIDTH-1:0] r_rd_data;
    logic                   r_rd_vld;
    logic                   r_fwd_hit;
    logic [COUNT_WIDTH-1:0] r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_vld  <= r_valid[i_rd_addr];
        end
        r_fwd_data <= i_wr_data;
    end

    // valid bits: entry never written since reset reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_fwd_hit <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            // read and write of the same entry on one edge: read sees the data being written
            r_fwd_hit <= i_ctl.rd_en && i_ctl.wr_en && (i_rd_addr == i_wr_addr);
        end
    end

    always_comb begin
        if (r_fwd_hit) begin
            o_rd_data = r_fwd_data;
        end else if (r_rd_vld) begin
            o_rd_data = r_rd_data;
        end else begin
            o_rd_data = '0;
        end
    end

endmodule

@@ sv/pixel_histogram_engine_core.sv @@
// Top level of the pixel histogram engine: command decode, read-modify-write
// pipeline around the bin store, peak tracker and result register.
// Depends on phe_pkg, phe_cfg_regs and phe_bin_store.
//
//  channel   | signals                                     | handshake
//  ----------+---------------------------------------------+---------------------------
//  command   | i_cmd, i_pixel_value, i_bin_index           | start && !busy
//  result    | o_count_value, o_echo_index                 | o_result_valid, one cycle
//  config    | psel penable pwrite paddr pwdata prdata     | APB, pready always high
//
// Timing: one item is taken every clock. An item's store address is computed
// and read in its accept cycle; the next cycle modifies and writes the entry
// back; the result (bin or peak read) shows on the cycle after that. The single
// store write port sets the one-item-per-clock figure; back-to-back hits on one
// bin are forwarded inside the store. Reset (i_rst_n low, synchronous) clears
// the per-bin valid bits at once, so no clearing pass follows it. busy stays
// low, and the receiver cannot stall results.
module pixel_histogram_engine_core #(
    parameter int MAX_BINS    = 256,
    parameter int COUNT_WIDTH = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // APB configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [phe_pkg::PADDR_W-1:0]       paddr,
    input  logic [phe_pkg::PDATA_W-1:0]       pwdata,
    output logic [phe_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready,
    // command item
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_cmd,
    input  logic [phe_pkg::PIXEL_W-1:0]       i_pixel_value,
    input  logic [phe_pkg::INDEX_W-1:0]       i_bin_index,
    // result item
    output logic                              o_result_valid,
    output logic [phe_pkg::OUT_COUNT_W-1:0]   o_count_value,
    output logic [phe_pkg::INDEX_W-1:0]       o_echo_index
);

    localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam int PROD_W = phe_pkg::PIXEL_W + phe_pkg::BIN_COUNT_W;

    // ---------------- stage 0: decode and address ----------------
    logic [phe_pkg::BIN_COUNT_W-1:0] w_eff_bins;
    logic                            w_accept;
    logic [PROD_W-1:0]               w_prod;
    logic [AW-1:0]                   w_bin;
    logic                            w_in_range;
    logic [AW-1:0]                   w_rd_addr;
    phe_pkg::t_store_ctl             w_ctl;

    // ---------------- stage 1: modify and write back -------------
    logic                            r_s1_valid;
    phe_pkg::t_cmd                   r_s1_cmd;
    logic [AW-1:0]                   r_s1_addr;
    logic [phe_pkg::INDEX_W-1:0]     r_s1_idx;
    logic                            r_s1_hit;
    logic [COUNT_WIDTH-1:0]          w_cur;
    logic [COUNT_WIDTH-1:0]          w_inc;
    logic [COUNT_WIDTH-1:0]          w_wr_data;
    logic                            w_wr_en;
    logic [COUNT_WIDTH-1:0]          r_peak;
    logic [COUNT_WIDTH-1:0]          n_peak;
    logic                            w_res_en;
    logic [COUNT_WIDTH-1:0]          w_res_count;
    logic [phe_pkg::INDEX_W-1:0]     w_res_idx;
    logic [COUNT_WIDTH+phe_pkg::OUT_COUNT_W-1:0] w_res_ext;

    // ---------------- result register ----------------------------
    logic                            r_res_valid;
    logic [phe_pkg::OUT_COUNT_W-1:0] r_res_count;
    logic [phe_pkg::INDEX_W-1:0]     r_res_idx;

    phe_cfg_regs #(
        .MAX_BINS (MAX_BINS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_eff_bins (w_eff_bins)
    );

    // every cycle can take an item; store hazards are forwarded, not stalled
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // bin = (pixel * bins) >> 8; always below bins, hence below MAX_BINS
    assign w_prod     = PROD_W'(i_pixel_value) * PROD_W'(w_eff_bins);
    assign w_bin      = w_prod[phe_pkg::PIXEL_W +: AW];
    assign w_in_range = ({1'b0, i_bin_index} < w_eff_bins);
    assign w_rd_addr  = (i_cmd == phe_pkg::CMD_COUNT) ? w_bin : i_bin_index[AW-1:0];

    assign w_ctl.rd_en = w_accept && ((i_cmd == phe_pkg::CMD_COUNT) ||
                         ((i_cmd == phe_pkg::CMD_READ) && w_in_range));
    assign w_ctl.wr_en = w_wr_en;

    phe_bin_store #(
        .MAX_BINS    (MAX_BINS),
        .COUNT_WIDTH (COUNT_WIDTH),
        .AW          (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_rd_addr (w_rd_addr),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (w_wr_data),
        .o_rd_data (w_cur)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
        end
        r_s1_cmd  <= i_cmd;
        r_s1_addr <= w_rd_addr;
        r_s1_idx  <= i_bin_index;
        r_s1_hit  <= w_in_range;
    end

    // saturating increment
    assign w_inc = (w_cur == COUNT_MAX) ? w_cur : w_cur + COUNT_WIDTH'(1);

    always_comb begin
        w_wr_en     = 1'b0;
        w_wr_data   = w_inc;
        n_peak      = r_peak;
        w_res_en    = 1'b0;
        w_res_count = '0;
        w_res_idx   = r_s1_idx;
        case (r_s1_cmd)
            phe_pkg::CMD_COUNT: begin
                w_wr_en = r_s1_valid;
                if (r_s1_valid && (w_inc > r_peak)) begin
                    n_peak = w_inc;
                end
            end
            phe_pkg::CMD_READ: begin
                w_res_en  = r_s1_valid;
                w_wr_data = '0;
                if (r_s1_hit) begin
                    w_res_count = w_cur;
                    w_wr_en     = r_s1_valid;
                end
            end
            phe_pkg::CMD_PEAK: begin
                w_res_en    = r_s1_valid;
                w_res_count = r_peak;
                w_res_idx   = '0;
                if (r_s1_valid) begin
                    n_peak = '0;
                end
            end
            default: begin
                // unused command: no store access, no result
                w_wr_en = 1'b0;
            end
        endcase
    end

    // result shows the low 24 bits of the counter
    assign w_res_ext = {{phe_pkg::OUT_COUNT_W{1'b0}}, w_res_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_peak      <= n_peak;
            r_res_valid <= w_res_en;
        end
        r_res_count <= w_res_ext[phe_pkg::OUT_COUNT_W-1:0];
        r_res_idx   <= w_res_idx;
    end

    assign o_result_valid = r_res_valid;
    assign o_count_value  = r_res_count;
    assign o_echo_index   = r_res_idx;

    // ---------------- assertions ----------------
    a_wr_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> r_s1_valid)
        else $error("store write without an item in the modify stage");

    a_result_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && ((r_s1_cmd == phe_pkg::CMD_READ) || (r_s1_cmd == phe_pkg::CMD_PEAK))
        |=> r_res_valid)
        else $error("read item produced no result");

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && (r_s1_cmd == phe_pkg::CMD_COUNT) |=> !r_res_valid)
        else $error("count item produced a result");

    a_peak_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && (r_s1_cmd == phe_pkg::CMD_PEAK) |=> (r_peak == '0))
        else $error("peak not cleared after peak read");

    a_peak_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en && (r_s1_cmd == phe_pkg::CMD_COUNT) |=> (r_peak >= $past(w_wr_data)))
        else $error("peak below a freshly written count");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for pixel_histogram_engine_core: a directed table and
// randomized commands, checked against a shadow histogram kept in this file.
// Depends on phe_pkg and the engine RTL.
module testbench;

    localparam phe_pkg::t_cmd CMD_NOP = 2'd3;          // unused command code
    localparam logic [phe_pkg::PADDR_W-1:0] ADDR_BIN_COUNT = {phe_pkg::REG_BIN_COUNT, 2'b00};
    localparam int HIST_DEPTH = 256;
    localparam logic [phe_pkg::OUT_COUNT_W-1:0] COUNT_FULL = '1;
    localparam int MAX_PRINTS = 40;

    typedef enum bit {ROW_ITEM, ROW_CFG} t_row_kind;

    // One line of the directed table; a fixed row carries its own expected result
    typedef struct packed {
        t_row_kind                       kind;
        phe_pkg::t_cmd                   cmd;
        logic [phe_pkg::PIXEL_W-1:0]     pix;
        logic [phe_pkg::INDEX_W-1:0]     idx;
        logic                            fixed;
        logic [phe_pkg::OUT_COUNT_W-1:0] cnt;
        logic [phe_pkg::INDEX_W-1:0]     echo;
        logic [phe_pkg::BIN_COUNT_W-1:0] cfg;
    } t_dir_row;

    typedef struct packed {
        logic [phe_pkg::OUT_COUNT_W-1:0] count;
        logic [phe_pkg::INDEX_W-1:0]     index;
    } t_read_result;

    localparam int N_ROWS = 37;

    // ---------------------------------------------------------------- signals
    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [phe_pkg::PADDR_W-1:0]     paddr = '0;
    logic [phe_pkg::PDATA_W-1:0]     pwdata = '0;
    logic [phe_pkg::PDATA_W-1:0]     prdata;
    logic                            pready;
    logic                            start = 1'b0;
    logic                            busy;
    logic [1:0]                      i_cmd = CMD_NOP;
    logic [phe_pkg::PIXEL_W-1:0]     i_pixel_value = '0;
    logic [phe_pkg::INDEX_W-1:0]     i_bin_index = '0;
    logic                            o_result_valid;
    logic [phe_pkg::OUT_COUNT_W-1:0] o_count_value;
    logic [phe_pkg::INDEX_W-1:0]     o_echo_index;

    // Typed expectation that travels alongside the item being offered
    logic                            item_fixed = 1'b0;
    logic [phe_pkg::OUT_COUNT_W-1:0] item_fixed_count = '0;
    logic [phe_pkg::INDEX_W-1:0]     item_fixed_echo = '0;

    // Shadow histogram state
    logic [phe_pkg::OUT_COUNT_W-1:0] hist_bins [HIST_DEPTH];
    logic [phe_pkg::OUT_COUNT_W-1:0] hist_peak;
    logic [phe_pkg::BIN_COUNT_W-1:0] hist_bin_count;

    t_read_result awaited_reads [$];
    int mismatch_count = 0;
    t_dir_row dir_table [0:N_ROWS-1];

    always #6 i_clk = ~i_clk;

    pixel_histogram_engine_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_pixel_value  (i_pixel_value),
        .i_bin_index    (i_bin_index),
        .o_result_valid (o_result_valid),
        .o_count_value  (o_count_value),
        .o_echo_index   (o_echo_index)
    );

    // ---------------------------------------------------------------- predictor
    // Register value 0 behaves as one bin, anything past the store depth as full depth
    function automatic int eff_bins(input logic [phe_pkg::BIN_COUNT_W-1:0] bc);
        if (bc == 0) return 1;
        if (bc > HIST_DEPTH) return HIST_DEPTH;
        return int'(bc);
    endfunction

    task automatic histogram_apply(input phe_pkg::t_cmd cmd,
                                   input logic [phe_pkg::PIXEL_W-1:0] pix,
                                   input logic [phe_pkg::INDEX_W-1:0] idx,
                                   output bit has_res,
                                   output t_read_result res);
        int nb;
        int b;
        logic [phe_pkg::OUT_COUNT_W-1:0] c;
        nb = eff_bins(hist_bin_count);
        has_res = 1'b0;
        res = '0;
        case (cmd)
            phe_pkg::CMD_COUNT: begin
                b = (int'(pix) * nb) >> 8;
                c = hist_bins[b];
                if (c != COUNT_FULL) c = c + 1'b1;    // saturate when full
                hist_bins[b] = c;
                if (c > hist_peak) hist_peak = c;
            end
            phe_pkg::CMD_READ: begin
                has_res = 1'b1;
                res.index = idx;
                // index past the live bin count reads zero and leaves the store alone
                if (int'(idx) < nb) begin
                    res.count = hist_bins[idx];
                    hist_bins[idx] = '0;
                end
            end
            phe_pkg::CMD_PEAK: begin
                has_res = 1'b1;
                res.count = hist_peak;
                hist_peak = '0;
            end
            default: ;                                // unused code: no effect
        endcase
    endtask

    task automatic flag_mismatch(input string what);
        if (mismatch_count < MAX_PRINTS)
            $display("%0t ns: mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // ---------------------------------------------------------------- monitor
    // Results are checked before the item taken at the same edge is predicted;
    // both sample pre-edge values.
    always @(posedge i_clk) begin
        bit has_res;
        t_read_result res;
        t_read_result want;
        if (i_rst_n) begin
            if (o_result_valid) begin
                if (awaited_reads.size() == 0) begin
                    flag_mismatch($sformatf("result with nothing pending: count %0d echo %0d",
                                            o_count_value, o_echo_index));
                end else begin
                    want = awaited_reads.pop_front();
                    if (o_count_value !== want.count)
                        flag_mismatch($sformatf("count_value %0d, want %0d (echo %0d)",
                                                o_count_value, want.count, want.index));
                    if (o_echo_index !== want.index)
                        flag_mismatch($sformatf("echo_index %0d, want %0d",
                                                o_echo_index, want.index));
                end
            end
            if (start && !busy) begin
                histogram_apply(phe_pkg::t_cmd'(i_cmd), i_pixel_value, i_bin_index,
                                has_res, res);
                if (has_res) begin
                    if (item_fixed) begin
                        res.count = item_fixed_count;
                        res.index = item_fixed_echo;
                    end
                    awaited_reads.push_back(res);
                end
            end
        end
    end

    // ---------------------------------------------------------------- drivers
    // All driver tasks start and end just after a rising edge.
    task automatic send_item(input phe_pkg::t_cmd cmd,
                             input logic [phe_pkg::PIXEL_W-1:0] pix,
                             input logic [phe_pkg::INDEX_W-1:0] idx, input logic fixed,
                             input logic [phe_pkg::OUT_COUNT_W-1:0] cnt,
                             input logic [phe_pkg::INDEX_W-1:0] echo);
        i_cmd            <= cmd;
        i_pixel_value    <= pix;
        i_bin_index      <= idx;
        item_fixed       <= fixed;
        item_fixed_count <= cnt;
        item_fixed_echo  <= echo;
        start            <= 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic idle_burst(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Drain: every read returned, then wait out count write-backs in flight
    task automatic wait_for_quiet();
        start <= 1'b0;
        @(posedge i_clk);
        while (awaited_reads.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_bin_count(input logic [phe_pkg::BIN_COUNT_W-1:0] v);
        logic [phe_pkg::PDATA_W-1:0] rb;
        // setup + access for the write; upper data bits are don't-care noise
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BIN_COUNT;
        pwdata  <= ($urandom() & ~32'h1FF) | {23'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        hist_bin_count = v;
        @(posedge i_clk);
        // read back
        psel   <= 1'b1;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rb = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rb !== {23'd0, v})
            flag_mismatch($sformatf("bin_count read back %0d, want %0d", rb, v));
        @(posedge i_clk);
    endtask

    task automatic send_random_item(input int nb);
        int r;
        phe_pkg::t_cmd cmd;
        logic [phe_pkg::PIXEL_W-1:0] pix;
        logic [phe_pkg::INDEX_W-1:0] idx;
        r = $urandom_range(0, 99);
        if (r < 65) cmd = phe_pkg::CMD_COUNT;
        else if (r < 85) cmd = phe_pkg::CMD_READ;
        else if (r < 93) cmd = phe_pkg::CMD_PEAK;
        else cmd = CMD_NOP;
        // a narrow hot band piles counts into a few bins so the peak moves
        if ($urandom_range(0, 3) == 0) pix = 8'(96 + $urandom_range(0, 7));
        else pix = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) != 0) idx = 8'($urandom_range(0, nb - 1));
        else idx = 8'($urandom_range(0, 255));
        send_item(cmd, pix, idx, 1'b0, '0, '0);
    endtask

    // ---------------------------------------------------------------- sequence
    initial begin
        logic [phe_pkg::BIN_COUNT_W-1:0] phase_cfg [10];
        int n_phases;
        int per_phase;
        for (int i = 0; i < HIST_DEPTH; i++) hist_bins[i] = '0;
        hist_peak = '0;
        hist_bin_count = phe_pkg::BIN_COUNT_RST;

        dir_table = '{
            // after reset everything reads zero; bin count is 30
            '{ROW_ITEM, phe_pkg::CMD_PEAK,  8'd0,   8'd0,   1'b1, 24'd0, 8'd0,   9'd0},
            '{ROW_ITEM, phe_pkg::CMD_READ,  8'd0,   8'd0,   1'b1, 24'd0, 8'd0,   9'd0},
            '{ROW_ITEM, phe_pkg::CMD_READ,  8'd0,   8'd255, 1'b1, 24'd0, 8'd255, 9'd0},
            '{ROW_ITEM, phe_pkg::CMD_READ,  8'd0,   8'd29,  1'b1, 24'd0, 8'd29,  9'd0},
            '{ROW_ITEM, CMD_NOP,            8'd255, 8'd255, 1'b0, 24'd0, 8'd0,   9'd0},
            // extremes of the pixel range, top pixel lands in bin 29
            '{ROW_ITEM, phe_pkg::CMD_COUNT, 8'd0,   8'd0,   1'b0, 24'd0, 8'd0,   9'd0},
            '{ROW_ITEM, phe_pkg::CMD_COUNT, 8'd255, 8'd0,   1'b0, 24'd0, 8'd0,   9'd0},
            '{ROW_ITEM, phe_pkg::CMD_COUNT, 8'd255, 8'd0,   1'b0, 24'd0, 8'd0,   9'd0},
            '{ROW_ITEM, phe_pkg::CMD_READ,  8'd0,   8'd29,  1'b1, 24'd2, 8'd29,  9'd0},
            // clearing a bin leaves the peak; reading the peak clears it
            '{ROW_ITEM, phe_pkg::CMD_PEAK,  8'd0,   8'd0,   1'b1, 24'd2, 8'd0,   9'd0},
            '{ROW_ITEM, phe_pkg::CMD_PEAK,  8'd0,   8'd0,   1'b1, 24'd0, 8'd0,   9'd0},
            '{ROW_ITEM, phe_pkg::CMD_READ,  8'd0,   8'd0,   1'b1, 24'd1, 8'd0,   9'd0},
            '{ROW_ITEM, phe_pkg::CMD_READ,  8'd0,   8'd0,   1'b1, 24'd0, 8'd0,   9'd0},
            '{ROW_ITEM, phe_pkg::CMD_COUNT, 8'd128, 8'd0,   1'b0, 24'd0, 8'd0,   9'd0},
            '{ROW_ITEM, phe_pkg::CMD_COUNT, 8'd127, 8'd0,   1'b0, 24'd0, 8'd0,   9'd0},
            // first index past the bin count
            '{ROW_ITEM, phe_pkg::CMD_READ,  8'd0,   8'd30,  1'b1, 24'd0, 8'd30,  9'd0},
            '{ROW_ITEM, phe_pkg::CMD_PEAK,  8'd0,   8'd0,   1'b0, 24'd0, 8'd0,   9'd0},
            '{ROW_ITEM, phe_pkg::CMD_READ,  8'd0,   8'd15,  1'b0, 24'd0, 8'd0,   9'd0},
            '{ROW_ITEM, phe_pkg::CMD_READ,  8'd0,   8'd14,  1'b0, 24'd0, 8'd0,   9'd0},
            // full depth
            '{ROW_CFG,  CMD_NOP,            8'd0,   8'd0,   1'b0, 24'd0, 8'd0,   9'd256},
            '{ROW_ITEM, phe_pkg::CMD_COUNT, 8'd255, 8'd0,   1'b0, 24'd0, 8'd0,   9'd0},
            '{ROW_ITEM, phe_pkg::CMD_COUNT, 8'd0,   8'd0,   1'b0, 24'd0, 8'd0,   9'd0},
            '{ROW_ITEM, phe_pkg::CMD_COUNT, 8'd250, 8'd0,   1'b0, 24'd0, 8'd0,   9'd0},
            '{ROW_ITEM, phe_pkg::CMD_READ,  8'd0,   8'd255, 1'b1, 24'd1, 8'd255, 9'd0},
            // one bin; bin 250 keeps its count but is hidden
            '{ROW_CFG,  CMD_NOP,            8'd0,   8'd0,   1'b0, 24'd0, 8'd0,   9'd1},
            '{ROW_ITEM, phe_pkg::CMD_COUNT, 8'd200, 8'd0,   1'b0, 24'd0, 8'd0,   9'd0},
            '{ROW_ITEM, phe_pkg::CMD_READ,  8'd0,   8'd0,   1'b0, 24'd0, 8'd0,   9'd0},
            '{ROW_ITEM, phe_pkg::CMD_READ,  8'd0,   8'd1,   1'b1, 24'd0, 8'd1,   9'd0},
            '{ROW_ITEM, phe_pkg::CMD_READ,  8'd0,   8'd250, 1'b1, 24'd0, 8'd250, 9'd0},
            // zero acts as one bin
            '{ROW_CFG,  CMD_NOP,            8'd0,   8'd0,   1'b0, 24'd0, 8'd0,   9'd0},
            '{ROW_ITEM, phe_pkg::CMD_COUNT, 8'd77,  8'd0,   1'b0, 24'd0, 8'd0,   9'd0},
            '{ROW_ITEM, phe_pkg::CMD_READ,  8'd0,   8'd0,   1'b1, 24'd1, 8'd0,   9'd0},
            // register maximum acts as full depth; bin 250 shows again
            '{ROW_CFG,  CMD_NOP,            8'd0,   8'd0,   1'b0, 24'd0, 8'd0,   9'd511},
            '{ROW_ITEM, phe_pkg::CMD_COUNT, 8'd255, 8'd0,   1'b0, 24'd0, 8'd0,   9'd0},
            '{ROW_ITEM, phe_pkg::CMD_READ,  8'd0,   8'd255, 1'b1, 24'd1, 8'd255, 9'd0},
            '{ROW_ITEM, phe_pkg::CMD_READ,  8'd0,   8'd250, 1'b0, 24'd0, 8'd0,   9'd0},
            '{ROW_ITEM, phe_pkg::CMD_PEAK,  8'd0,   8'd0,   1'b0, 24'd0, 8'd0,   9'd0}
        };

        phase_cfg = '{9'd30, 9'd256, 9'd1, 9'd0, 9'd2, 9'd255, 9'd511, 9'd128, 9'd257,
                      9'($urandom_range(0, 511))};
        n_phases  = 10;
        per_phase = 180;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed table
        for (int r = 0; r < N_ROWS; r++) begin
            if (dir_table[r].kind == ROW_CFG) begin
                wait_for_quiet();
                write_bin_count(dir_table[r].cfg);
            end else begin
                send_item(dir_table[r].cmd, dir_table[r].pix, dir_table[r].idx,
                          dir_table[r].fixed, dir_table[r].cnt, dir_table[r].echo);
                if ($urandom_range(0, 3) == 0) idle_burst($urandom_range(1, 15));
            end
        end

        // random phases, each under its own bin count; last phase runs back to back
        for (int p = 0; p < n_phases; p++) begin
            wait_for_quiet();
            write_bin_count(phase_cfg[p]);
            for (int k = 0; k < per_phase; k++) begin
                send_random_item(eff_bins(hist_bin_count));
                if (p == 3 && k == per_phase / 2) begin
                    // hold off until every pending read has come back
                    start <= 1'b0;
                    @(posedge i_clk);
                    while (awaited_reads.size() != 0) @(posedge i_clk);
                end else if (p != n_phases - 1 && $urandom_range(0, 5) == 0) begin
                    idle_burst($urandom_range(1, 15));
                end
            end
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (awaited_reads.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
